@@ design/tah_pkg.sv @@
`default_nettype none
package tah_pkg;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned PosW = 32;
  localparam int unsigned VelW = 24;
  localparam int unsigned AccW = 19;
  localparam int unsigned SlewW = 23;
  localparam int unsigned RangeW = 31;
  localparam int unsigned DistW = 33;
  localparam int unsigned ProdW = 57;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned UnitScale = 1000;

  localparam logic [CfgIdxW-1:0] RegHomingEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVelLow = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVelHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAccX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAccY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAccZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSlewStep = 3'd6;
  localparam logic [CfgIdxW-1:0] RegStopRange = 3'd7;

  localparam logic signed [VelW-1:0] VelLowReset = VelW'(-256 * UnitScale);
  localparam logic signed [VelW-1:0] VelHighReset = VelW'(256 * UnitScale);
  localparam logic [SlewW-1:0] SlewReset = SlewW'(1000);
  localparam logic [RangeW-1:0] RangeReset = RangeW'(1000);

  typedef struct packed {
    logic homing;
    logic signed [VelW-1:0] vel_low;
    logic signed [VelW-1:0] vel_high;
    logic [SlewW-1:0] slew;
    logic [RangeW-1:0] range;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic load;
  } lane_cmd_t;
endpackage
`default_nettype wire

@@ design/three_axis_homing_motion_integrator.sv @@
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_ready | op_i, value_x/y/z_i
// out     | output    | out_valid/out_ready | pos_x/y/z_o, vel_x/y/z_o
// cfg     | input     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// out_valid is registered after the lane's done flag: a load finishes in the idle
// state, a tick without homing passes StUpd, and a homing tick passes StMul, StDiv,
// StWait on the 57-step divider and StUpd; each axis lane runs in parallel.
// One transaction in flight at a time; the output register holds while out_ready
// is low. Reset clears lane positions and velocities (pos_x/y/z_o are not reset) and loads register defaults.
`default_nettype none
module three_axis_homing_motion_integrator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op_i,
  input  wire logic signed [tah_pkg::PosW-1:0]     value_x_i,
  input  wire logic signed [tah_pkg::PosW-1:0]     value_y_i,
  input  wire logic signed [tah_pkg::PosW-1:0]     value_z_i,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tah_pkg::PosW-1:0]          pos_x_o,
  output logic signed [tah_pkg::PosW-1:0]          pos_y_o,
  output logic signed [tah_pkg::PosW-1:0]          pos_z_o,
  output logic signed [tah_pkg::VelW-1:0]          vel_x_o,
  output logic signed [tah_pkg::VelW-1:0]          vel_y_o,
  output logic signed [tah_pkg::VelW-1:0]          vel_z_o,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tah_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [tah_pkg::CfgDataW-1:0]        cfg_data_i
);
  tah_pkg::cfg_t cfg_q;
  logic signed [tah_pkg::AccW-1:0] acc_q [tah_pkg::NumAxes];
  logic busy_q;
  tah_pkg::lane_cmd_t cmd;
  logic [tah_pkg::NumAxes-1:0] lane_done, done_q;
  logic signed [tah_pkg::PosW-1:0] val [tah_pkg::NumAxes];
  logic signed [tah_pkg::PosW-1:0] pos [tah_pkg::NumAxes];
  logic signed [tah_pkg::VelW-1:0] vel [tah_pkg::NumAxes];
  logic [tah_pkg::NumAxes-1:0] all_done;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy_q && !out_valid;
  assign cmd.start = in_valid && in_ready;
  assign cmd.load = op_i;
  assign val[0] = value_x_i;
  assign val[1] = value_y_i;
  assign val[2] = value_z_i;
  assign all_done = done_q | lane_done;

  for (genvar k = 0; k < tah_pkg::NumAxes; k++) begin : g_lane
    tah_lane u_lane (
      .clk_i, .rst_ni, .cmd_i(cmd), .value_i(val[k]), .cfg_i(cfg_q),
      .acc_i(acc_q[k]), .done_o(lane_done[k]), .pos_o(pos[k]), .vel_o(vel[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.homing <= 1'b0;
      cfg_q.vel_low <= tah_pkg::VelLowReset;
      cfg_q.vel_high <= tah_pkg::VelHighReset;
      cfg_q.slew <= tah_pkg::SlewReset;
      cfg_q.range <= tah_pkg::RangeReset;
      for (int k = 0; k < tah_pkg::NumAxes; k++) acc_q[k] <= '0;
      busy_q <= 1'b0;
      done_q <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index_i)
          tah_pkg::RegHomingEnable: cfg_q.homing <= cfg_data_i[0];
          tah_pkg::RegVelLow: cfg_q.vel_low <= cfg_data_i[tah_pkg::VelW-1:0];
          tah_pkg::RegVelHigh: cfg_q.vel_high <= cfg_data_i[tah_pkg::VelW-1:0];
          tah_pkg::RegAccX: acc_q[0] <= cfg_data_i[tah_pkg::AccW-1:0];
          tah_pkg::RegAccY: acc_q[1] <= cfg_data_i[tah_pkg::AccW-1:0];
          tah_pkg::RegAccZ: acc_q[2] <= cfg_data_i[tah_pkg::AccW-1:0];
          tah_pkg::RegSlewStep: cfg_q.slew <= cfg_data_i[tah_pkg::SlewW-1:0];
          tah_pkg::RegStopRange: cfg_q.range <= cfg_data_i[tah_pkg::RangeW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.start) begin
        busy_q <= 1'b1;
        done_q <= '0;
      end else if (busy_q) begin
        // merge: wait until every lane has finished
        if (&all_done) begin
          busy_q <= 1'b0;
          out_valid <= 1'b1;
          done_q <= '0;
        end else begin
          done_q <= all_done;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && (&all_done)) begin
      pos_x_o <= pos[0];
      pos_y_o <= pos[1];
      pos_z_o <= pos[2];
    end
  end

  assign vel_x_o = vel[0];
  assign vel_y_o = vel[1];
  assign vel_z_o = vel[2];

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(busy_q && out_valid))
    else $error("busy with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (lane_done != '0) |-> busy_q)
    else $error("lane finished while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
endmodule
`default_nettype wire

@@ design/tah_div.sv @@
`default_nettype none
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module tah_div (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  input  wire logic signed [tah_pkg::ProdW-1:0]        num_i,
  input  wire logic        [tah_pkg::RangeW-1:0]       den_i,
  output logic                                         done_o,
  output logic signed [tah_pkg::ProdW-1:0]             quo_o
);
  localparam int unsigned W = tah_pkg::ProdW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] quo_q;
  logic [tah_pkg::RangeW:0] rem_q;
  logic [tah_pkg::RangeW-1:0] den_q;
  logic neg_q, busy_q;
  logic [CntW-1:0] cnt_q;
  logic [tah_pkg::RangeW+1:0] trial;
  logic [tah_pkg::RangeW+1:0] shifted;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial = shifted - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[W-1] ? W'(-num_i) : num_i;
      rem_q <= '0;
      den_q <= (den_i == '0) ? tah_pkg::RangeW'(1) : den_i;
      neg_q <= num_i[W-1];
    end else if (busy_q) begin
      if (!trial[tah_pkg::RangeW+1]) begin
        rem_q <= trial[tah_pkg::RangeW:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[tah_pkg::RangeW:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign quo_o = neg_q ? W'(-quo_q) : quo_q;
endmodule
`default_nettype wire

@@ design/tah_lane.sv @@
`default_nettype none
// One axis: load, or tick: distance; if homing, product, divide, slew limit; accelerate, clamp, advance.
module tah_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tah_pkg::lane_cmd_t                   cmd_i,
  input  wire logic signed [tah_pkg::PosW-1:0]      value_i,
  input  wire tah_pkg::cfg_t                        cfg_i,
  input  wire logic signed [tah_pkg::AccW-1:0]      acc_i,
  output logic                                      done_o,
  output logic signed [tah_pkg::PosW-1:0]           pos_o,
  output logic signed [tah_pkg::VelW-1:0]           vel_o
);
  typedef enum logic [2:0] {StIdle, StMul, StDiv, StWait, StUpd} state_e;
  state_e state_q;

  logic signed [tah_pkg::PosW-1:0] pos_q;
  logic signed [tah_pkg::VelW-1:0] vel_q;
  logic signed [tah_pkg::DistW-1:0] dist_q;
  logic signed [tah_pkg::ProdW-1:0] prod_q;
  logic signed [tah_pkg::ProdW-1:0] want_q;
  logic div_done;
  logic signed [tah_pkg::ProdW-1:0] quo;
  logic signed [tah_pkg::ProdW-1:0] lo, hi, steer;
  logic signed [tah_pkg::ProdW-1:0] v_acc;
  logic signed [tah_pkg::VelW-1:0] v_new;

  tah_div u_div (
    .clk_i, .rst_ni,
    .start_i(state_q == StDiv),
    .num_i(prod_q),
    .den_i(cfg_i.range),
    .done_o(div_done),
    .quo_o(quo)
  );

  always_comb begin
    lo = tah_pkg::ProdW'(vel_q) - tah_pkg::ProdW'({1'b0, cfg_i.slew});
    hi = tah_pkg::ProdW'(vel_q) + tah_pkg::ProdW'({1'b0, cfg_i.slew});
    if (!cfg_i.homing) steer = tah_pkg::ProdW'(vel_q);
    else if (want_q < lo) steer = lo;
    else if (want_q > hi) steer = hi;
    else steer = want_q;
    v_acc = steer + tah_pkg::ProdW'(acc_i);
    if (v_acc > tah_pkg::ProdW'(cfg_i.vel_high)) v_new = cfg_i.vel_high;
    else if (v_acc < tah_pkg::ProdW'(cfg_i.vel_low)) v_new = cfg_i.vel_low;
    else v_new = v_acc[tah_pkg::VelW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q <= '0;
      vel_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == StUpd) || (state_q == StIdle && cmd_i.start && cmd_i.load);
      case (state_q)
        StIdle: begin
          if (cmd_i.start && cmd_i.load) begin
            pos_q <= value_i;
          end else if (cmd_i.start) begin
            state_q <= cfg_i.homing ? StMul : StUpd;
          end
        end
        StMul: state_q <= StDiv;
        StDiv: state_q <= StWait;
        StWait: if (div_done) state_q <= StUpd;
        StUpd: begin
          vel_q <= v_new;
          pos_q <= pos_q + tah_pkg::PosW'(v_new);
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_i.start)
      dist_q <= tah_pkg::DistW'(value_i) - tah_pkg::DistW'(pos_q);
    if (state_q == StMul)
      prod_q <= tah_pkg::ProdW'(dist_q) * tah_pkg::ProdW'(cfg_i.vel_high);
    if (div_done) want_q <= quo;
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;

  // div finishes only while lanes wait on it
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == StWait)
    else $error("divider result outside wait");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> state_q == StIdle)
    else $error("lane done outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && cmd_i.start && cmd_i.load) |=> $stable(vel_q))
    else $error("load changed velocity");
endmodule
`default_nettype wire
